[src/rthsl_pkg.sv]
package rthsl_pkg;

  // Sextant bases for the hue numerator
  localparam logic [1:0] SEXT_RED   = 2'd0;
  localparam logic [1:0] SEXT_GREEN = 2'd1;
  localparam logic [1:0] SEXT_BLUE  = 2'd2;

  localparam int QW   = 31; // quotient width
  localparam int DENW = 12; // 6*d <= 1530

  // Classified pixel handed from front to back
  typedef struct packed {
    logic [8:0]  sum;       // mx + mn
    logic [7:0]  dif;       // mx - mn
    logic [11:0] hue_num;   // hue numerator, < 6d
    logic [8:0]  sat_den;   // saturation denominator
    logic        frame_end;
  } rthsl_item_t;

  // rounded q = (2*num*65535 + den) / (2*den), unrolled as a pipelined divider step
  function automatic logic [QW+DENW:0] div_step(input logic [QW+DENW:0] acc,
                                                input logic [DENW:0] den);
    logic [DENW+1:0] trial;
    logic [QW+DENW:0] res;
    begin
      trial = {acc[QW+DENW:QW-1]} - {1'b0, den};
      res = acc << 1;
      if (!trial[DENW+1]) begin
        res[QW+DENW:QW] = trial[DENW:0];
        res[0] = 1'b1;
      end
      return res;
    end
  endfunction

endpackage

[src/rthsl_front.sv]
module rthsl_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic               in_frame_end_in,
  output logic               q_valid,
  input  logic               q_stall,
  output rthsl_pkg::rthsl_item_t q_item
);
  logic [7:0] mx, mn;
  logic [1:0] sext;
  rthsl_pkg::rthsl_item_t item;

  // Two-entry queue
  rthsl_pkg::rthsl_item_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic       push, pop;

  always_comb begin
    mx = in_red; sext = rthsl_pkg::SEXT_RED;
    if (in_green > mx) begin mx = in_green; sext = rthsl_pkg::SEXT_GREEN; end
    if (in_blue > mx) begin mx = in_blue; sext = rthsl_pkg::SEXT_BLUE; end
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    item.sum = {1'b0, mx} + {1'b0, mn};
    item.dif = mx - mn;
    item.frame_end = in_frame_end_in;
    item.sat_den = (item.sum < 9'd255) ? item.sum : 9'(10'd510 - {1'b0, item.sum});
    case (sext)
      rthsl_pkg::SEXT_RED: begin
        if (in_green >= in_blue) item.hue_num = {4'd0, in_green - in_blue};
        else item.hue_num = 12'(12'd6 * item.dif) - {4'd0, in_blue - in_green};
      end
      rthsl_pkg::SEXT_GREEN:
        item.hue_num = 12'({item.dif, 1'b0} + 12'(in_blue)) - 12'(in_red);
      default:
        item.hue_num = 12'({item.dif, 2'b0} + 12'(in_red)) - 12'(in_green);
    endcase
  end

  assign in_stall = cnt_r[1];
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt_r != 2'd0;
  assign pop      = q_valid && !q_stall;
  assign q_item   = buf_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    rd_nxt  = rd_r ^ pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; rd_r <= rd_nxt; wr_r <= wr_nxt;
    end
    if (push) buf_r[wr_r] <= item;
  end
endmodule

[src/rthsl_back.sv]
module rthsl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_stall,
  input  rthsl_pkg::rthsl_item_t q_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_hue,
  output logic [15:0]        out_saturation,
  output logic [15:0]        out_lightness,
  output logic               out_frame_end_out
);
  localparam int AW = rthsl_pkg::QW + rthsl_pkg::DENW + 1;
  localparam int NS = rthsl_pkg::QW;
  localparam int DW = rthsl_pkg::DENW + 1;

  typedef struct packed {
    logic [AW-1:0] acc_h, acc_s;
    logic [DW-1:0] den_h, den_s;
    logic [15:0]   lig;
    logic          grey;
    logic          fe;
  } stage_t;

  stage_t      st_r   [NS+1];
  stage_t      st_nxt [NS+1];
  logic        v_r    [NS+1];
  stage_t      s0;
  logic        adv;
  logic [16:0] lig_full;

  // whole pipe advances together; stalls when output is held
  assign adv     = !(v_r[NS] && out_stall);
  assign q_stall = !adv;

  always_comb begin
    // dividend 2*num*65535, denominator 2*den
    s0.acc_h = AW'(({19'd0, q_item.hue_num} << 17) - ({19'd0, q_item.hue_num} << 1));
    s0.acc_s = AW'(({22'd0, q_item.dif} << 17) - ({22'd0, q_item.dif} << 1));
    s0.den_h = DW'({q_item.dif, 1'b0} * 13'd6);
    s0.den_s = DW'({q_item.sat_den, 1'b0});
    // rounding term: add den
    s0.acc_h = s0.acc_h + AW'(s0.den_h >> 1);
    s0.acc_s = s0.acc_s + AW'(s0.den_s >> 1);
    // 65535/510 is exactly 257/2, so lightness is (257*s + 1) >> 1
    lig_full = {8'd0, q_item.sum} * 17'd257 + 17'd1;
    s0.lig   = lig_full[16:1];
    s0.grey  = q_item.dif == 8'd0;
    s0.fe    = q_item.frame_end;
  end

  // one quotient bit per stage (restoring division)
  always_comb begin
    st_nxt[0] = s0;
    for (int i = 1; i <= NS; i++) begin
      st_nxt[i]       = st_r[i-1];
      st_nxt[i].acc_h = rthsl_pkg::div_step(st_r[i-1].acc_h, st_r[i-1].den_h);
      st_nxt[i].acc_s = rthsl_pkg::div_step(st_r[i-1].acc_s, st_r[i-1].den_s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= q_valid;
      for (int i = 1; i <= NS; i++) v_r[i] <= v_r[i-1];
    end
    if (adv) begin
      for (int i = 0; i <= NS; i++) st_r[i] <= st_nxt[i];
    end
  end

  assign out_valid         = v_r[NS];
  assign out_hue           = st_r[NS].grey ? 16'd0 : st_r[NS].acc_h[15:0];
  assign out_saturation    = st_r[NS].grey ? 16'd0 : st_r[NS].acc_s[15:0];
  assign out_lightness     = st_r[NS].lig;
  assign out_frame_end_out = st_r[NS].fe;
endmodule

[src/rgb_to_hsl_pixel.sv]
// RGB to HSL pixel converter.
// Path from input transfer to result: queue, operand stage, and
// 31 restoring-division stages, one quotient bit each.
// Throughput: one pixel per cycle; the pipe holds on a stalled valid output.
// Reset (synchronous, rst_n low) empties the queue and clears pipeline valids.
module rgb_to_hsl_pixel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        in_frame_end_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_hue,
  output logic [15:0] out_saturation,
  output logic [15:0] out_lightness,
  output logic        out_frame_end_out
);
  logic q_valid, q_stall;
  rthsl_pkg::rthsl_item_t q_item;

  // front: max/min, sextant and numerators, into a two-entry queue
  rthsl_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_red, .in_green, .in_blue,
    .in_frame_end_in, .q_valid, .q_stall, .q_item
  );

  // back: hue and saturation as rounded divisions in a bit-per-stage pipeline;
  // lightness is a constant product carried alongside
  rthsl_back u_back (
    .clk, .rst_n, .q_valid, .q_stall, .q_item, .out_valid, .out_stall,
    .out_hue, .out_saturation, .out_lightness, .out_frame_end_out
  );
endmodule
